>>> hw/rtl/fcpwm_pkg.sv
// types and constants shared by the four-channel pwm timer register block
package fcpwm_pkg;

  localparam int unsigned DATA_W = 32;

  // item modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // address map
  localparam logic [7:0] GLOBAL_ADDR = 8'h00;
  localparam logic [7:0] CH_BASE     = 8'h10;
  localparam int unsigned CH_STRIDE  = 16;

  // register slot within a channel
  localparam logic [1:0] SLOT_CTRL   = 2'd0;
  localparam logic [1:0] SLOT_PERIOD = 2'd1;
  localparam logic [1:0] SLOT_DUTY   = 2'd2;
  localparam logic [1:0] SLOT_COUNT  = 2'd3;

  // ctrl bits
  localparam int unsigned CTRL_W     = 3;
  localparam int unsigned CTRL_EN    = 0;
  localparam int unsigned CTRL_IRQEN = 2;
  localparam int unsigned DONE_LSB   = 4;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        addr;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
  } out_item_t;

  typedef struct packed {
    logic wr_ctrl;
    logic wr_period;
    logic wr_duty;
    logic tick;
  } chan_cmd_t;

  typedef struct packed {
    logic [CTRL_W-1:0] ctrl;
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] duty;
    logic [DATA_W-1:0] count;
    logic              done_set;
  } chan_stat_t;

endpackage

>>> hw/rtl/fcpwm_chan.sv
// one timer channel: ctrl, period, duty and count registers with tick logic
module fcpwm_chan
  import fcpwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  chan_cmd_t         cmd,
  input  logic [DATA_W-1:0] wdata,
  output chan_stat_t        stat
);

  logic [CTRL_W-1:0] ctrl_r,   ctrl_nxt;
  logic [DATA_W-1:0] period_r, period_nxt;
  logic [DATA_W-1:0] duty_r,   duty_nxt;
  logic [DATA_W-1:0] count_r,  count_nxt;
  logic [DATA_W-1:0] count_inc;
  logic              wrap;
  logic              advance;

  assign count_inc = count_r + DATA_W'(1);
  assign wrap      = (period_r != '0) && (count_inc >= period_r);
  assign advance   = cmd.tick && ctrl_r[CTRL_EN];

  always_comb begin
    ctrl_nxt   = cmd.wr_ctrl   ? wdata[CTRL_W-1:0] : ctrl_r;
    period_nxt = cmd.wr_period ? wdata : period_r;
    duty_nxt   = cmd.wr_duty   ? wdata : duty_r;
    count_nxt  = count_r;
    if (advance) begin
      count_nxt = wrap ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      period_r <= '0;
      duty_r   <= '0;
      count_r  <= '0;
    end else begin
      ctrl_r   <= ctrl_nxt;
      period_r <= period_nxt;
      duty_r   <= duty_nxt;
      count_r  <= count_nxt;
    end
  end

  always_comb begin
    stat.ctrl     = ctrl_r;
    stat.period   = period_r;
    stat.duty     = duty_r;
    stat.count    = count_r;
    stat.done_set = advance && wrap;
  end

endmodule

>>> hw/rtl/four_channel_pwm_counter_regs_core.sv
// top level of the multi-channel pwm timer register block
// Register block of a pwm timer with up to four channels in a 256-byte window. Each input item is
// a register read, a register write or one timer tick, and each gives exactly one result item
// carrying the read data (zero unless a valid read) and the interrupt level after that item. The
// block takes one item per clock while the result side keeps up: an item sits in the input
// register, and its register update and result are formed from there and land in the result
// register as soon as that register is free or being emptied. The path that sets the clock is the
// per-channel 32-bit count increment and compare against the period. Input and result registers
// decouple the two sides: while a result is held, one more item is still accepted into the input
// register, and the input stalls only once both registers are full.
module four_channel_pwm_counter_regs_core
  import fcpwm_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [8:0] CH_END = 9'(CH_BASE) + 9'(CH_STRIDE * NUM_CHANNELS);

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  logic      fire;

  logic [NUM_CHANNELS-1:0] done_r, done_nxt, done_set, irqen_nxt;
  logic [7:0]  rel;
  logic        ch_hit;
  logic [1:0]  ch_sel;
  logic [1:0]  slot;
  logic        is_read, is_write, is_tick;
  logic [DATA_W-1:0] rd_data;
  logic        irq_nxt;

  chan_cmd_t  cmd  [NUM_CHANNELS];
  chan_stat_t stat [NUM_CHANNELS];

  // the item in the input register moves on whenever the result register is free
  assign fire      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || fire;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  always_comb begin
    is_read  = 1'b0;
    is_write = 1'b0;
    is_tick  = 1'b0;
    unique case (in_item_r.mode)
      MODE_READ:  is_read  = 1'b1;
      MODE_WRITE: is_write = 1'b1;
      MODE_TICK:  is_tick  = 1'b1;
      default: ;
    endcase
  end

  // channel address decode
  assign rel    = in_item_r.addr - CH_BASE;
  assign ch_hit = (in_item_r.addr >= CH_BASE) && ({1'b0, in_item_r.addr} < CH_END)
                  && (rel[1:0] == 2'b00);
  assign ch_sel = rel[5:4];
  assign slot   = rel[3:2];

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    logic sel_wr;

    assign sel_wr = fire && is_write && ch_hit && (ch_sel == 2'(i));

    always_comb begin
      cmd[i].wr_ctrl   = sel_wr && (slot == SLOT_CTRL);
      cmd[i].wr_period = sel_wr && (slot == SLOT_PERIOD);
      cmd[i].wr_duty   = sel_wr && (slot == SLOT_DUTY);
      cmd[i].tick      = fire && is_tick;
    end

    fcpwm_chan u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[i]),
      .wdata (in_item_r.write_data),
      .stat  (stat[i])
    );

    assign done_set[i]  = stat[i].done_set;
    assign irqen_nxt[i] = cmd[i].wr_ctrl ? in_item_r.write_data[CTRL_IRQEN]
                                         : stat[i].ctrl[CTRL_IRQEN];
  end

  // done flags: write 1 to clear from the global register, set on period wrap
  always_comb begin
    done_nxt = done_r | done_set;
    if (fire && is_write && (in_item_r.addr == GLOBAL_ADDR)) begin
      done_nxt = done_r & ~in_item_r.write_data[DONE_LSB +: NUM_CHANNELS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else begin
      done_r <= done_nxt;
    end
  end

  assign irq_nxt = |(done_nxt & irqen_nxt);

  always_comb begin
    rd_data = '0;
    if (is_read) begin
      if (in_item_r.addr == GLOBAL_ADDR) begin
        rd_data[DONE_LSB +: NUM_CHANNELS] = done_r;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          rd_data[i] = stat[i].ctrl[CTRL_EN];
        end
      end else if (ch_hit) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (ch_sel == 2'(i)) begin
            unique case (slot)
              SLOT_CTRL:   rd_data = DATA_W'(stat[i].ctrl);
              SLOT_PERIOD: rd_data = stat[i].period;
              SLOT_DUTY:   rd_data = stat[i].duty;
              SLOT_COUNT:  rd_data = stat[i].count;
              default:     rd_data = '0;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r.read_data <= rd_data;
      out_item_r.irq       <= irq_nxt;
    end
  end

  // a held result always matches the timer state, which only moves with it
  a_irq_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_item_r.irq == |(done_r & irqen_nxt) || fire))
    else $error("irq in result register does not match done and irq enable state");

  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_read) |=> (out_item_r.read_data == '0))
    else $error("non-read item produced nonzero read data");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a stalled result");

  a_done_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_write && (in_item_r.addr == GLOBAL_ADDR)) |=>
      ((done_r & $past(in_item_r.write_data[DONE_LSB +: NUM_CHANNELS])) == '0))
    else $error("write 1 to clear left a done flag set");

endmodule

>>> sim/four_channel_pwm_counter_regs_core_tb.sv
// testbench for the four-channel pwm timer register block with a self-checking scoreboard
`timescale 1ns / 1ps

module four_channel_pwm_counter_regs_core_tb
  import fcpwm_pkg::*;
();

  localparam int unsigned NCH       = 4;
  localparam logic [1:0]  MODE_NOP  = 2'd3;
  localparam int unsigned LIMIT     = 100000;
  localparam int unsigned BREAK_PCT = 38;
  localparam int unsigned N_RANDOM  = 400;

  class pwm_timer_sb;
    logic [CTRL_W-1:0] ctrl [NCH];
    logic [DATA_W-1:0] period [NCH];
    logic [DATA_W-1:0] duty [NCH];
    logic [DATA_W-1:0] count [NCH];
    logic [NCH-1:0]    done;
    out_item_t         awaited[$];
    int                errors;

    function new();
      for (int i = 0; i < NCH; i++) begin
        ctrl[i]   = '0;
        period[i] = '0;
        duty[i]   = '0;
        count[i]  = '0;
      end
      done   = '0;
      errors = 0;
    endfunction

    // word-aligned register of a channel that exists
    function bit chan_hit(logic [7:0] addr, output int ch, output logic [1:0] slot);
      ch   = int'(addr[7:4]) - 1;
      slot = addr[3:2];
      return addr >= CH_BASE && int'(addr) < int'(CH_BASE) + NCH * CH_STRIDE &&
             addr[1:0] == 2'b00;
    endfunction

    function void note_input(in_item_t it);
      out_item_t   exp;
      int          ch;
      logic [1:0]  slot;
      exp.read_data = '0;
      case (it.mode)
        MODE_READ: begin
          if (it.addr == GLOBAL_ADDR) begin
            for (int i = 0; i < NCH; i++) begin
              exp.read_data[i]            = ctrl[i][CTRL_EN];
              exp.read_data[DONE_LSB + i] = done[i];
            end
          end else if (chan_hit(it.addr, ch, slot)) begin
            case (slot)
              SLOT_CTRL:   exp.read_data = DATA_W'(ctrl[ch]);
              SLOT_PERIOD: exp.read_data = period[ch];
              SLOT_DUTY:   exp.read_data = duty[ch];
              default:     exp.read_data = count[ch];
            endcase
          end
        end
        MODE_WRITE: begin
          if (it.addr == GLOBAL_ADDR) begin
            done = done & ~it.write_data[DONE_LSB +: NCH];
          end else if (chan_hit(it.addr, ch, slot)) begin
            case (slot)
              SLOT_CTRL:   ctrl[ch]   = it.write_data[CTRL_W-1:0];
              SLOT_PERIOD: period[ch] = it.write_data;
              SLOT_DUTY:   duty[ch]   = it.write_data;
              default:     ;  // count is read only
            endcase
          end
        end
        MODE_TICK: begin
          for (int i = 0; i < NCH; i++) begin
            if (ctrl[i][CTRL_EN]) begin
              count[i] = count[i] + 1;
              if (period[i] != '0 && count[i] >= period[i]) begin
                count[i] = '0;
                done[i]  = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      exp.irq = 1'b0;
      for (int i = 0; i < NCH; i++) begin
        if (done[i] && ctrl[i][CTRL_IRQEN]) exp.irq = 1'b1;
      end
      awaited.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (awaited.size() == 0) begin
        $error("unexpected result item: read_data %h irq %b", got.read_data, got.irq);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.read_data !== exp.read_data) begin
        $error("read_data: expected %h, actual %h", exp.read_data, got.read_data);
        errors++;
      end
      if (got.irq !== exp.irq) begin
        $error("irq: expected %b, actual %b", exp.irq, got.irq);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  bit        calm;
  int        cycles = 0;

  pwm_timer_sb sb = new();

  four_channel_pwm_counter_regs_core #(
    .NUM_CHANNELS(NCH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit take_break();
    return !calm && $urandom_range(99) < BREAK_PCT;
  endfunction

  function automatic logic [7:0] reg_addr(int ch, logic [1:0] slot);
    return CH_BASE + 8'(ch * CH_STRIDE) + {4'h0, slot, 2'b00};
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [7:0] addr,
                           input logic [DATA_W-1:0] wdata);
    in_item_t it;
    it.mode       = mode;
    it.addr       = addr;
    it.write_data = wdata;
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic send_random();
    int              r;
    int              ch;
    logic [1:0]      slot;
    logic [1:0]      mode;
    logic [7:0]      addr;
    logic [DATA_W-1:0] wdata;
    r     = $urandom_range(99);
    ch    = $urandom_range(NCH - 1);
    slot  = 2'($urandom_range(3));
    addr  = ($urandom_range(5) == 0) ? GLOBAL_ADDR : reg_addr(ch, slot);
    wdata = $urandom;
    if (r < 12) begin
      // noise over the whole window and every mode
      mode = 2'($urandom_range(3));
      addr = 8'($urandom_range(255));
    end else if (r < 55) begin
      mode = MODE_TICK;
    end else if (r < 78) begin
      mode = MODE_READ;
    end else begin
      mode = MODE_WRITE;
      // mostly short periods so counters wrap and done flags fire
      if (addr != GLOBAL_ADDR && slot == SLOT_PERIOD && $urandom_range(7) != 0)
        wdata = $urandom_range(12);
    end
    send_item(mode, addr, wdata);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !take_break();
    end
  end

  initial begin : result_monitor
    out_item_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = out_item;
        #1 sb.check_result(got);
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_item  = '0;
    rst_n    = 1'b0;
    calm     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(MODE_READ,  GLOBAL_ADDR, '0);
    // ctrl write with junk above the 3 ctrl bits
    send_item(MODE_WRITE, reg_addr(0, SLOT_CTRL),   32'hFFFF_FFFD);
    send_item(MODE_WRITE, reg_addr(0, SLOT_PERIOD), 32'd2);
    send_item(MODE_WRITE, reg_addr(0, SLOT_DUTY),   32'hFFFF_FFFF);
    send_item(MODE_TICK,  8'h00, 32'hFFFF_FFFF);
    send_item(MODE_TICK,  8'hFF, '0);
    send_item(MODE_READ,  GLOBAL_ADDR, '0);
    send_item(MODE_READ,  reg_addr(0, SLOT_CTRL), '0);
    // count is read only
    send_item(MODE_WRITE, reg_addr(0, SLOT_COUNT), 32'h1234_5678);
    send_item(MODE_TICK,  8'h00, '0);
    send_item(MODE_READ,  reg_addr(0, SLOT_COUNT), '0);
    // global write with only non-done bits set clears nothing
    send_item(MODE_WRITE, GLOBAL_ADDR, 32'hFFFF_FF0F);
    send_item(MODE_WRITE, GLOBAL_ADDR, 32'h0000_0010);
    // done without irq enable, then irq enable raises the line at once
    send_item(MODE_WRITE, reg_addr(3, SLOT_CTRL),   32'd1);
    send_item(MODE_WRITE, reg_addr(3, SLOT_PERIOD), 32'd1);
    send_item(MODE_TICK,  8'h00, '0);
    send_item(MODE_WRITE, reg_addr(3, SLOT_CTRL),   32'd5);
    // zero period lets the count run, then a period below the count ends it
    send_item(MODE_WRITE, reg_addr(1, SLOT_CTRL),   32'd1);
    send_item(MODE_TICK,  8'h00, '0);
    send_item(MODE_TICK,  8'h00, '0);
    send_item(MODE_WRITE, reg_addr(1, SLOT_PERIOD), 32'd1);
    send_item(MODE_TICK,  8'h00, '0);
    // invalid addresses: unaligned, past the last channel, top of window
    send_item(MODE_READ,  8'h11, '0);
    send_item(MODE_READ,  8'h50, '0);
    send_item(MODE_WRITE, 8'hFF, 32'hFFFF_FFFF);
    send_item(MODE_NOP,   8'hFF, 32'hFFFF_FFFF);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 150 && n < 230);
      send_random();
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
